// ----- rtl/tasd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tasd_pkg;

  localparam int NUM_KEYS = 12;
  localparam int LED_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [10:0] UPPER_CAM_STEPS   = 11'd133;
  localparam logic [10:0] LOWER_CAM_STEPS   = 11'd128;
  localparam logic [10:0] UPPER_EXTRA_STEPS = 11'd19;
  localparam logic [10:0] LOWER_EXTRA_STEPS = 11'd12;

  localparam logic [7:0]  RST_PHASE_TICKS = 8'd3;
  localparam logic [7:0]  RST_BLINK_TICKS = 8'd25;
  localparam logic [15:0] RST_KEY_TIMEOUT = 16'd15000;
  localparam logic [11:0] RST_SETTLE      = 12'd500;
  localparam logic [12:0] RST_CHECK_HOLD  = 13'd2000;
  localparam logic [16:0] RST_IDLE_REHOME = 17'd60000;
  localparam logic [10:0] RST_HOME_OFFSET = 11'd684;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_TICKS  = 3'd0,
    CFG_BLINK_TICKS  = 3'd1,
    CFG_KEY_TIMEOUT  = 3'd2,
    CFG_SETTLE       = 3'd3,
    CFG_CHECK_HOLD   = 3'd4,
    CFG_IDLE_REHOME  = 3'd5,
    CFG_HOME_OFFSET  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]       cam_coils;
    logic [3:0]       gear_coils;
    logic [LED_W-1:0] key_leds;
    logic             busy_res;
    logic             accepted;
    logic             timed_out;
  } result_t;

  typedef struct packed {
    logic        go;
    logic [1:0]  idx;
    logic [7:0]  tmr;
    logic [10:0] step;
    logic [3:0]  drive;
  } motor_t;

  typedef struct packed {
    logic       go;
    logic [1:0] idx;
    logic [7:0] tmr;
    logic       on;
  } blink_t;

  // full-step patterns, CW 9,C,6,3 and CCW 3,6,C,9
  function automatic logic [3:0] coil_pat(logic cw, logic [1:0] idx);
    logic [3:0] p;
    case ({cw, idx})
      3'b000:  p = 4'h3;
      3'b001:  p = 4'h6;
      3'b010:  p = 4'hC;
      3'b011:  p = 4'h9;
      3'b100:  p = 4'h9;
      3'b101:  p = 4'hC;
      3'b110:  p = 4'h6;
      default: p = 4'h3;
    endcase
    return p;
  endfunction

  // |offset| per key, key index 0..11
  function automatic logic [9:0] key_mag(logic [3:0] kidx);
    logic [9:0] m;
    case (kidx)
      4'd0, 4'd5, 4'd6, 4'd11: m = 10'd688;
      4'd1, 4'd4, 4'd7, 4'd10: m = 10'd452;
      default:                 m = 10'd118;
    endcase
    return m;
  endfunction

  // positive offset moves right (CW)
  function automatic logic key_right(logic [3:0] kidx);
    logic r;
    case (kidx)
      4'd3, 4'd4, 4'd5, 4'd9, 4'd10, 4'd11: r = 1'b1;
      default:                              r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic motor_t motor_step(logic want, logic cw, logic [7:0] ticks,
                                        logic [1:0] idx, logic [7:0] tmr,
                                        logic [10:0] step, logic [3:0] drive);
    motor_t     r;
    logic [7:0] p;
    logic [7:0] t;
    p       = (ticks == 8'd0) ? 8'd1 : ticks;
    r.go    = 1'b1;
    r.idx   = idx;
    r.tmr   = tmr;
    r.step  = step;
    r.drive = drive;
    if (tmr == 8'd0 && idx == 2'd0 && !want) begin
      r.go = 1'b0;
    end else begin
      if (tmr == 8'd0) begin
        r.drive = coil_pat(cw, idx);
        r.idx   = idx + 2'd1;
        t       = p;
      end else begin
        t = tmr;
      end
      r.tmr = t - 8'd1;
      if (r.tmr == 8'd0 && r.idx == 2'd0) begin
        r.step = step + 11'd1;
      end
    end
    return r;
  endfunction

  function automatic blink_t blink_step(logic want, logic [7:0] ticks, logic [1:0] idx,
                                        logic [7:0] tmr, logic on);
    blink_t     r;
    logic [7:0] b;
    logic [7:0] t;
    b     = (ticks == 8'd0) ? 8'd1 : ticks;
    r.go  = 1'b1;
    r.idx = idx;
    r.tmr = tmr;
    r.on  = on;
    if (tmr == 8'd0 && idx == 2'd0 && !want) begin
      r.go = 1'b0;
    end else begin
      if (tmr == 8'd0) begin
        if (idx == 2'd0) begin
          r.on  = 1'b1;
          r.idx = 2'd1;
        end else begin
          r.on  = 1'b0;
          r.idx = 2'd0;
        end
        t = b;
      end else begin
        t = tmr;
      end
      r.tmr = t - 8'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tasd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tasd_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  key_number;
  logic        cam_limit;
  logic        gear_limit;
  logic [11:0] key_sensors;

  modport source (output valid, req_type, key_number, cam_limit, gear_limit, key_sensors,
                  input ready);
  modport sink (input valid, req_type, key_number, cam_limit, gear_limit, key_sensors,
                output ready);
endinterface

interface tasd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cam_coils;
  logic [3:0]  gear_coils;
  logic [11:0] key_leds;
  logic        busy_res;
  logic        accepted;
  logic        timed_out;

  modport source (output valid, cam_coils, gear_coils, key_leds, busy_res, accepted,
                  timed_out, input ready);
  modport sink (input valid, cam_coils, gear_coils, key_leds, busy_res, accepted,
                timed_out, output ready);
endinterface

interface tasd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tasd_pkg::CFG_IDX_W-1:0]  index;
  logic [tasd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/two_axis_stepper_key_dispense_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake            payload
// in_if     in   valid/ready          req_type, key_number, cam_limit, gear_limit, key_sensors
// out_if    out  valid/ready          cam_coils, gear_coils, key_leds, busy_res, accepted,
//                                     timed_out
// cfg_if    in   valid/ready (ready=1) index, data
//
// One request per cycle while in_if.ready is high: the sequencer state updates in the cycle a request is taken.
// The result lands in a two-entry output queue; in_if.ready drops only when both are full.
// Config writes are always taken.
// Reset starts the horizontal homing run with the register defaults loaded.

module two_axis_stepper_key_dispense_sequencer (
  input  wire        clk_i,
  input  wire        rst_ni,
  tasd_in_if.sink    in_if,
  tasd_out_if.source out_if,
  tasd_cfg_if.sink   cfg_if
);

  typedef enum logic [4:0] {
    S_HAPP   = 5'd0,
    S_HSET   = 5'd1,
    S_HOFF   = 5'd2,
    S_IDLE   = 5'd3,
    S_GOUT   = 5'd4,
    S_GOSET  = 5'd5,
    S_CAMOUT = 5'd6,
    S_CLOW   = 5'd7,
    S_CHIGH  = 5'd8,
    S_HOLD   = 5'd9,
    S_CBACK  = 5'd10,
    S_CEXTRA = 5'd11,
    S_CSET   = 5'd12,
    S_GBACK  = 5'd13,
    S_GBSET  = 5'd14
  } state_e;

  localparam logic [16:0] CNT_MAX = 17'h1FFFF;

  // config registers
  logic [7:0]  phase_ticks_q, blink_ticks_q;
  logic [15:0] key_timeout_q;
  logic [11:0] settle_q;
  logic [12:0] check_hold_q;
  logic [16:0] idle_rehome_q;
  logic [10:0] home_offset_q;

  // sequencer state
  state_e      st_q, st_d;
  logic [1:0]  idx_q, idx_d;
  logic [7:0]  tmr_q, tmr_d;
  logic [10:0] step_q, step_d;
  logic [16:0] wt_q, wt_d;
  logic [3:0]  key_q, key_d;
  logic [3:0]  cam_q, cam_d;
  logic [3:0]  gear_q, gear_d;
  logic        blink_q, blink_d;
  logic [16:0] ic_q, ic_d;
  logic        armed_q, armed_d;

  // output queue
  tasd_pkg::result_t fifo_q [2];
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q;

  logic in_fire, out_fire, cfg_fire;
  assign in_fire  = in_if.valid & in_if.ready;
  assign out_fire = out_if.valid & out_if.ready;
  assign cfg_fire = cfg_if.valid & cfg_if.ready;

  assign in_if.ready  = (cnt_q != 2'd2);
  assign cfg_if.ready = 1'b1;

  // current key decode
  logic [3:0] kidx;
  logic       upper, sensor, k_right, key_ok;
  logic [10:0] kmag;
  assign kidx    = (key_q >= 4'd1 && key_q <= 4'd12) ? key_q - 4'd1 : 4'd0;
  assign upper   = (kidx <= 4'd5);
  assign sensor  = in_if.key_sensors[kidx];
  assign k_right = tasd_pkg::key_right(kidx);
  assign kmag    = {1'b0, tasd_pkg::key_mag(kidx)};
  assign key_ok  = (in_if.key_number >= 4'd1) &&
                   ({1'b0, in_if.key_number} <= 5'(tasd_pkg::NUM_KEYS)) &&
                   (in_if.key_number <= 4'd12);

  // shared step unit
  logic               m_want, m_cw, m_cam, g_right, expired;
  tasd_pkg::motor_t   m;
  logic               b_want;
  tasd_pkg::blink_t   b;

  assign expired = (wt_q > {1'b0, key_timeout_q});
  assign g_right = (st_q == S_GOUT) ? k_right : !k_right;

  always_comb begin
    m_want = 1'b0;
    m_cw   = 1'b0;
    m_cam  = 1'b0;
    case (st_q)
      S_HAPP: begin
        m_want = !in_if.gear_limit;
        m_cw   = 1'b1;
      end
      S_HOFF: begin
        m_want = (step_q < home_offset_q);
      end
      S_GOUT, S_GBACK: begin
        m_cw   = g_right;
        m_want = g_right ? ((step_q < kmag) && !((step_q != 11'd0) && in_if.gear_limit))
                         : (step_q < kmag);
      end
      S_CAMOUT: begin
        m_cam  = 1'b1;
        m_cw   = upper;
        m_want = step_q < (upper ? tasd_pkg::UPPER_CAM_STEPS : tasd_pkg::LOWER_CAM_STEPS);
      end
      S_CBACK: begin
        m_cam  = 1'b1;
        m_cw   = !upper;
        m_want = in_if.cam_limit;
      end
      S_CEXTRA: begin
        m_cam  = 1'b1;
        m_cw   = !upper;
        m_want = step_q < (upper ? tasd_pkg::UPPER_EXTRA_STEPS
                                 : tasd_pkg::LOWER_EXTRA_STEPS);
      end
      default: begin
        m_want = 1'b0;
      end
    endcase
  end

  assign m = tasd_pkg::motor_step(m_want, m_cw, phase_ticks_q, idx_q, tmr_q, step_q,
                                  m_cam ? cam_q : gear_q);
  assign b_want = (st_q == S_CLOW) ? (!sensor && !expired) : sensor;
  assign b = tasd_pkg::blink_step(b_want, blink_ticks_q, idx_q, tmr_q, blink_q);

  // sequencer next state
  logic        ent, ent_wt_en, to, acc;
  state_e      ent_st;
  logic [16:0] ent_wt, ic_inc;
  tasd_pkg::result_t res;

  always_comb begin
    st_d      = st_q;
    idx_d     = idx_q;
    tmr_d     = tmr_q;
    step_d    = step_q;
    wt_d      = wt_q;
    key_d     = key_q;
    cam_d     = cam_q;
    gear_d    = gear_q;
    blink_d   = blink_q;
    ic_d      = ic_q;
    armed_d   = armed_q;
    ent       = 1'b0;
    ent_st    = st_q;
    ent_wt_en = 1'b0;
    ent_wt    = 17'd0;
    to        = 1'b0;
    acc       = 1'b0;
    ic_inc    = (ic_q != CNT_MAX) ? ic_q + 17'd1 : ic_q;

    if (in_if.req_type) begin
      if (st_q == S_IDLE && key_ok) begin
        key_d  = in_if.key_number;
        acc    = 1'b1;
        ent    = 1'b1;
        ent_st = S_GOUT;
      end
    end else begin
      case (st_q)
        S_HAPP, S_HOFF, S_GOUT, S_CAMOUT, S_CBACK, S_CEXTRA, S_GBACK: begin
          if (m.go) begin
            idx_d  = m.idx;
            tmr_d  = m.tmr;
            step_d = m.step;
            if (m_cam) begin
              cam_d = m.drive;
            end else begin
              gear_d = m.drive;
            end
          end else begin
            ent = 1'b1;
            case (st_q)
              S_HAPP: begin
                ent_st    = S_HSET;
                ent_wt_en = 1'b1;
                ent_wt    = {5'd0, settle_q};
              end
              S_HOFF: begin
                gear_d = 4'd0;
                ent_st = S_IDLE;
              end
              S_GOUT: begin
                ent_st    = S_GOSET;
                ent_wt_en = 1'b1;
                ent_wt    = {5'd0, settle_q};
              end
              S_CAMOUT: begin
                cam_d     = 4'd0;
                ent_st    = S_CLOW;
                ent_wt_en = 1'b1;
                ent_wt    = 17'd0;
              end
              S_CBACK: begin
                ent_st = S_CEXTRA;
              end
              S_CEXTRA: begin
                cam_d     = 4'd0;
                ent_st    = S_CSET;
                ent_wt_en = 1'b1;
                ent_wt    = {5'd0, settle_q};
              end
              default: begin
                ent_st    = S_GBSET;
                ent_wt_en = 1'b1;
                ent_wt    = {5'd0, settle_q};
              end
            endcase
          end
        end
        S_HSET, S_GOSET, S_HOLD, S_CSET, S_GBSET: begin
          if (wt_q > 17'd1) begin
            wt_d = wt_q - 17'd1;
          end else begin
            wt_d = 17'd0;
            ent  = 1'b1;
            case (st_q)
              S_HSET:  ent_st = S_HOFF;
              S_GOSET: ent_st = S_CAMOUT;
              S_HOLD:  ent_st = S_CBACK;
              S_CSET:  ent_st = S_GBACK;
              default: begin
                gear_d  = 4'd0;
                ent_st  = S_IDLE;
                armed_d = 1'b1;
                ic_d    = 17'd0;
              end
            endcase
          end
        end
        S_CLOW, S_CHIGH: begin
          if (b.go) begin
            idx_d   = b.idx;
            tmr_d   = b.tmr;
            blink_d = b.on;
            if (st_q == S_CLOW && wt_q != CNT_MAX) begin
              wt_d = wt_q + 17'd1;
            end
          end else begin
            ent = 1'b1;
            if (st_q == S_CLOW) begin
              to     = expired;
              ent_st = S_CHIGH;
            end else begin
              ent_st    = S_HOLD;
              ent_wt_en = 1'b1;
              ent_wt    = {4'd0, check_hold_q};
            end
          end
        end
        S_IDLE: begin
          if (armed_q) begin
            ic_d = ic_inc;
            if (ic_inc >= idle_rehome_q) begin
              armed_d = 1'b0;
              ent     = 1'b1;
              ent_st  = S_HAPP;
            end
          end
        end
        default: begin
          cam_d  = 4'd0;
          gear_d = 4'd0;
          ent    = 1'b1;
          ent_st = S_IDLE;
        end
      endcase
    end

    if (ent) begin
      st_d    = ent_st;
      idx_d   = 2'd0;
      tmr_d   = 8'd0;
      step_d  = 11'd0;
      blink_d = 1'b0;
      if (ent_wt_en) begin
        wt_d = ent_wt;
      end
    end

    res.cam_coils  = cam_d;
    res.gear_coils = gear_d;
    res.key_leds   = (blink_d && key_d >= 4'd1 && key_d <= 4'd12) ?
                     (tasd_pkg::LED_W'(1) << (key_d - 4'd1)) : '0;
    res.busy_res   = (st_d != S_IDLE);
    res.accepted   = acc;
    res.timed_out  = to;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_HAPP;
      idx_q   <= 2'd0;
      tmr_q   <= 8'd0;
      step_q  <= 11'd0;
      wt_q    <= 17'd0;
      key_q   <= 4'd0;
      cam_q   <= 4'd0;
      gear_q  <= 4'd0;
      blink_q <= 1'b0;
      ic_q    <= 17'd0;
      armed_q <= 1'b0;
    end else if (in_fire) begin
      st_q    <= st_d;
      idx_q   <= idx_d;
      tmr_q   <= tmr_d;
      step_q  <= step_d;
      wt_q    <= wt_d;
      key_q   <= key_d;
      cam_q   <= cam_d;
      gear_q  <= gear_d;
      blink_q <= blink_d;
      ic_q    <= ic_d;
      armed_q <= armed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= tasd_pkg::RST_PHASE_TICKS;
      blink_ticks_q <= tasd_pkg::RST_BLINK_TICKS;
      key_timeout_q <= tasd_pkg::RST_KEY_TIMEOUT;
      settle_q      <= tasd_pkg::RST_SETTLE;
      check_hold_q  <= tasd_pkg::RST_CHECK_HOLD;
      idle_rehome_q <= tasd_pkg::RST_IDLE_REHOME;
      home_offset_q <= tasd_pkg::RST_HOME_OFFSET;
    end else if (cfg_fire) begin
      case (cfg_if.index)
        tasd_pkg::CFG_PHASE_TICKS: phase_ticks_q <= cfg_if.data[7:0];
        tasd_pkg::CFG_BLINK_TICKS: blink_ticks_q <= cfg_if.data[7:0];
        tasd_pkg::CFG_KEY_TIMEOUT: key_timeout_q <= cfg_if.data[15:0];
        tasd_pkg::CFG_SETTLE:      settle_q      <= cfg_if.data[11:0];
        tasd_pkg::CFG_CHECK_HOLD:  check_hold_q  <= cfg_if.data[12:0];
        tasd_pkg::CFG_IDLE_REHOME: idle_rehome_q <= cfg_if.data[16:0];
        tasd_pkg::CFG_HOME_OFFSET: home_offset_q <= cfg_if.data[10:0];
        default: ;
      endcase
    end
  end

  // output queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (in_fire) begin
        wr_q <= ~wr_q;
      end
      if (out_fire) begin
        rd_q <= ~rd_q;
      end
      if (in_fire && !out_fire) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!in_fire && out_fire) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fifo_q[wr_q] <= res;
    end
  end

  assign out_if.valid      = (cnt_q != 2'd0);
  assign out_if.cam_coils  = fifo_q[rd_q].cam_coils;
  assign out_if.gear_coils = fifo_q[rd_q].gear_coils;
  assign out_if.key_leds   = fifo_q[rd_q].key_leds;
  assign out_if.busy_res   = fifo_q[rd_q].busy_res;
  assign out_if.accepted   = fifo_q[rd_q].accepted;
  assign out_if.timed_out  = fifo_q[rd_q].timed_out;

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_if.req_type && st_q == S_IDLE && key_ok |=> st_q == S_GOUT)
    else $error("dispense request did not start the sequence");

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_IDLE |-> cam_q == 4'd0 && gear_q == 4'd0)
    else $error("coils driven while idle");

  a_wait_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE || st_q == S_HOLD || st_q == S_CSET) |-> idx_q == 2'd0 && tmr_q == 8'd0)
    else $error("phase state left over in a pause");

  a_queue_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !out_fire |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("output queue lost a result");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !out_fire |=> cnt_q == 2'd2 && $stable(wr_q))
    else $error("output queue overwritten");

endmodule

`default_nettype wire
